// ===== sv/sst_pkg.sv =====
// Shared types and constants for the sorted set table.
package sst_pkg;

  // Store depth and derived widths
  localparam int DEPTH  = 64;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int VW     = 32;
  localparam int OUT_W  = 1 + 2 + CW;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_CHANGED  = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_PROBE_CHK,
    S_DECIDE,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DN,
    S_FINISH
  } state_t;

  // Memory port request from the sequencer
  typedef struct packed {
    logic            we;
    addr_t           waddr;
    logic [VW-1:0]   wdata;
    logic            re;
    addr_t           raddr;
  } ram_req_t;

  // Finished result handed to the output stage
  typedef struct packed {
    logic    valid;
    logic    was_present;
    status_t status;
    cnt_t    size_after;
  } result_t;

endpackage

// ===== sv/sst_ram.sv =====
// Generic simple dual-port RAM with registered read.
module sst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/sst_ctrl.sv =====
// Sequencer: binary search, shift passes and member count.
module sst_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  sst_pkg::opcode_t        in_op,
  input  logic [sst_pkg::VW-1:0]  in_value,
  output sst_pkg::ram_req_t       ram_req,
  input  logic [sst_pkg::VW-1:0]  rd_data,
  output sst_pkg::result_t        res,
  input  logic                    res_ready
);
  import sst_pkg::*;

  state_t        state, state_next;
  opcode_t       op;
  logic [VW-1:0] value;
  cnt_t          lo, hi, count, ptr;
  cnt_t          mid, count_next;
  logic          present;
  status_t       status;
  logic          wr_pend;
  addr_t         wr_addr;
  logic          up_rd, dn_rd, accept;

  // Search midpoint and shift-pass conditions
  assign mid    = lo + ((hi - lo) >> 1);
  assign up_rd  = (ptr > lo);
  assign dn_rd  = ((ptr + cnt_t'(1)) < count);
  assign accept = in_valid && in_ready;

  // Count after this operation
  always_comb begin
    count_next = count;
    if (op == OP_CLEAR) begin
      count_next = '0;
    end else if (status == ST_CHANGED && op == OP_INSERT) begin
      count_next = count + cnt_t'(1);
    end else if (status == ST_CHANGED && op == OP_REMOVE) begin
      count_next = count - cnt_t'(1);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (in_op == OP_CLEAR) ? S_FINISH : S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (lo < hi) begin
          state_next = S_SRCH_CMP;
        end else if (lo < count) begin
          state_next = S_PROBE_CHK;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_SRCH_CMP:  state_next = S_SRCH_RD;
      S_PROBE_CHK: state_next = S_DECIDE;
      S_DECIDE: begin
        if (op == OP_INSERT && !present && count != cnt_t'(DEPTH)) begin
          state_next = S_SHIFT_UP;
        end else if (op == OP_REMOVE && present) begin
          state_next = S_SHIFT_DN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT_UP: begin
        if (!up_rd && !wr_pend) begin
          state_next = S_PUT;
        end
      end
      S_PUT: state_next = S_FINISH;
      S_SHIFT_DN: begin
        if (!dn_rd && !wr_pend) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: handshake, memory requests, result
  always_comb begin
    in_ready      = (state == S_IDLE);
    ram_req       = '0;
    res.valid       = (state == S_FINISH);
    res.was_present = present;
    res.status      = status;
    res.size_after  = count_next;
    unique case (state)
      S_SRCH_RD: begin
        if (lo < hi) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = mid[AW-1:0];
        end else if (lo < count) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = lo[AW-1:0];
        end
      end
      S_SHIFT_UP: begin
        ram_req.re    = up_rd;
        ram_req.raddr = addr_t'(ptr - cnt_t'(1));
        ram_req.we    = wr_pend;
        ram_req.waddr = wr_addr;
        ram_req.wdata = rd_data;
      end
      S_PUT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = lo[AW-1:0];
        ram_req.wdata = value;
      end
      S_SHIFT_DN: begin
        ram_req.re    = dn_rd;
        ram_req.raddr = addr_t'(ptr + cnt_t'(1));
        ram_req.we    = wr_pend;
        ram_req.waddr = wr_addr;
        ram_req.wdata = rd_data;
      end
      default: begin
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Count and shift-pass control
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      wr_pend <= 1'b0;
    end else begin
      unique case (state)
        S_DECIDE:   wr_pend <= 1'b0;
        S_SHIFT_UP: wr_pend <= up_rd;
        S_SHIFT_DN: wr_pend <= dn_rd;
        S_FINISH: begin
          if (res_ready) begin
            count <= count_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op      <= in_op;
          value   <= in_value;
          lo      <= '0;
          hi      <= count;
          present <= 1'b0;
          status  <= (count != '0) ? ST_CHANGED : ST_NOCHANGE;
        end
      end
      S_SRCH_CMP: begin
        // lower bound: move past entries below the key
        if ($signed(rd_data) < $signed(value)) begin
          lo <= mid + cnt_t'(1);
        end else begin
          hi <= mid;
        end
      end
      S_PROBE_CHK: present <= (rd_data == value);
      S_DECIDE: begin
        if (op == OP_INSERT && !present) begin
          status <= (count == cnt_t'(DEPTH)) ? ST_FULL : ST_CHANGED;
          ptr    <= count;
        end else if (op == OP_REMOVE && present) begin
          status <= ST_CHANGED;
          ptr    <= lo;
        end else begin
          status <= ST_NOCHANGE;
        end
      end
      S_SHIFT_UP: begin
        wr_addr <= ptr[AW-1:0];
        if (up_rd) begin
          ptr <= ptr - cnt_t'(1);
        end
      end
      S_SHIFT_DN: begin
        wr_addr <= ptr[AW-1:0];
        if (dn_rd) begin
          ptr <= ptr + cnt_t'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/sst_out.sv =====
// Output register stage for result transfers.
module sst_out (
  input  logic                       clk,
  input  logic                       rst,
  input  sst_pkg::result_t           res,
  output logic                       res_ready,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [sst_pkg::OUT_TW-1:0] m_tdata
);
  import sst_pkg::*;

  // Free when empty or being drained this cycle
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res.valid;
    end
  end

  // Payload: was_present, status, size_after from bit 0 up
  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      m_tdata <= OUT_TW'({res.size_after, res.status, res.was_present});
    end
  end

endmodule

// ===== sv/sorted_set_table.sv =====
// Top level of the sorted set table.
// Sorted set table: holds up to DEPTH distinct signed 32-bit values in ascending order in
// one synchronous RAM with a member count, and serves lookup, insert, remove and clear
// requests one at a time. Each request yields one result transfer carrying was_present,
// status (changed, no change, rejected because full) and the count afterwards. A request
// runs a binary search for the lower bound of its value, then checks the slot found if it
// holds a member; an insert of an absent value into a store with room then shifts the
// entries from that place up and writes the value, and a remove of a member shifts the
// entries above it down, as the shift pass moves one entry per cycle through the single
// RAM read and write port. A clear skips the search. No clearing pass runs after reset;
// only entries below the count are ever read. A result waiting in the output register
// does not block the next request from being accepted; the request after it waits until
// that result has been taken.
module sorted_set_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [sst_pkg::VW-1:0]     s_tdata,  // value
  input  logic [1:0]                 s_tuser,  // opcode
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [sst_pkg::OUT_TW-1:0] m_tdata   // was_present, status, size_after, zero fill
);
  import sst_pkg::*;

  ram_req_t      ram_req;
  logic [VW-1:0] rd_data;
  result_t       res;
  logic          res_ready;

  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (opcode_t'(s_tuser)),
    .in_value  (s_tdata),
    .ram_req   (ram_req),
    .rd_data   (rd_data),
    .res       (res),
    .res_ready (res_ready)
  );

  sst_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  sst_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_ready (res_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== sv/sst_checker.sv =====
// Port-level assertions for the sorted set table, bound to the top level.
module sst_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [sst_pkg::VW-1:0]     s_tdata,
  input logic [1:0]                 s_tuser,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [sst_pkg::OUT_TW-1:0] m_tdata
);
  import sst_pkg::*;

  logic    was_present;
  status_t status;
  cnt_t    size_after;

  assign was_present = m_tdata[0];
  assign status      = status_t'(m_tdata[2:1]);
  assign size_after  = m_tdata[3 +: CW];

  // One request in flight: no transfer right after an accepted one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted back to back");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // Only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (status == ST_CHANGED || status == ST_NOCHANGE || status == ST_FULL))
    else $error("undefined status code");

  // Rejected insert only with a full store and an absent value
  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == ST_FULL) |-> (!was_present && size_after == cnt_t'(DEPTH)))
    else $error("full rejection with wrong count or presence");

  // Count never exceeds the store depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (size_after <= cnt_t'(DEPTH)))
    else $error("count beyond depth");

endmodule

bind sorted_set_table sst_checker u_sst_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== dv/sorted_set_table_check.sv =====
// Checker for the sorted set table: mirrors the set, predicts each result and compares.
module sorted_set_table_check (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [sst_pkg::VW-1:0]     s_tdata,   // value
  input  logic [1:0]                 s_tuser,   // opcode
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [sst_pkg::OUT_TW-1:0] m_tdata,   // was_present, status, size_after, zero fill
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sst_pkg::*;

  typedef struct packed {
    logic    was_present;
    status_t status;
    cnt_t    size_after;
  } set_result_t;

  // Mirror of the set: members[0..member_total-1] ascending
  logic signed [VW-1:0] members [DEPTH];
  int                   member_total;
  set_result_t          expected_results [$];
  int                   mismatch_count = 0;

  assign errors = mismatch_count;

  // Lower bound: first slot whose member is not below the key
  function automatic int search_place(logic signed [VW-1:0] key);
    int lo, hi, mid;
    lo = 0;
    hi = member_total;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (members[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Apply one request to the mirror and return its result
  function automatic set_result_t apply_request(opcode_t op, logic signed [VW-1:0] key);
    set_result_t r;
    int          place;
    bit          hit;
    r.was_present = 1'b0;
    r.status      = ST_NOCHANGE;
    if (op == OP_CLEAR) begin
      r.status     = (member_total != 0) ? ST_CHANGED : ST_NOCHANGE;
      member_total = 0;
    end else begin
      place = search_place(key);
      hit   = (place < member_total) && (members[place] == key);
      r.was_present = hit;
      if (op == OP_INSERT && !hit) begin
        if (member_total >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = member_total; i > place; i--) members[i] = members[i-1];
          members[place] = key;
          member_total++;
          r.status = ST_CHANGED;
        end
      end else if (op == OP_REMOVE && hit) begin
        for (int i = place; i + 1 < member_total; i++) members[i] = members[i+1];
        member_total--;
        r.status = ST_CHANGED;
      end
    end
    r.size_after = cnt_t'(member_total);
    return r;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // Predict on each request transfer, compare on each result transfer
  always @(posedge clk) begin
    set_result_t want;
    if (rst) begin
      member_total = 0;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_results.push_back(apply_request(opcode_t'(s_tuser), $signed(s_tdata)));
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result transfer with none expected: expected none, actual %h",
                   $time, m_tdata);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("was_present", 32'(want.was_present), 32'(m_tdata[0]));
          check_field("status", 32'(want.status), 32'(m_tdata[2:1]));
          check_field("size_after", 32'(want.size_after), 32'(m_tdata[3 +: CW]));
          check_field("fill bits", 32'd0, 32'(m_tdata[OUT_TW-1:OUT_W]));
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

// ===== dv/sorted_set_table_test.sv =====
// Testbench top for the sorted set table: clock, reset, request stimulus and verdict.
module sorted_set_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sst_pkg::*;

  localparam int QUIET_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 480;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [VW-1:0]     s_tdata = '0;     // value
  logic [1:0]        s_tuser = '0;     // opcode
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_TW-1:0] m_tdata;          // was_present, status, size_after, zero fill

  int errors;
  int pending;
  int send_idle = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  sorted_set_table u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sorted_set_table_check u_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  // Result side: random stalls, or a long hold-off when requested
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        hold_left = hold_len;
        hold_len  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request transfer, after a random number of idle cycles
  task automatic send_request(opcode_t op, logic [VW-1:0] value);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering and wait until every result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly a narrow key range so hits and a full store are common
  function automatic logic [VW-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return VW'(int'($urandom_range(79)) - 40);
    if (roll < 78) return 32'h8000_0000 + $urandom_range(3);
    if (roll < 86) return 32'h7FFF_FFFF - $urandom_range(3);
    return $urandom();
  endfunction

  // Filling runs favor insert, draining runs favor remove and carry the clears
  function automatic opcode_t pick_op(bit filling);
    int unsigned roll;
    roll = $urandom_range(99);
    if (filling) begin
      if (roll < 75) return OP_INSERT;
      if (roll < 85) return OP_REMOVE;
      return OP_LOOKUP;
    end
    if (roll < 3) return OP_CLEAR;
    if (roll < 60) return OP_REMOVE;
    if (roll < 85) return OP_LOOKUP;
    return OP_INSERT;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty set, extremes, duplicates, absent keys, first/last/middle removal
    send_request(OP_LOOKUP, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0005);
    send_request(OP_CLEAR,  32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_INSERT, 32'h7FFF_FFFF);
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_INSERT, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h0000_0001);
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'h8000_0000);
    send_request(OP_LOOKUP, 32'h0000_0007);
    send_request(OP_REMOVE, 32'h0000_0007);
    send_request(OP_REMOVE, 32'h7FFF_FFFF);
    send_request(OP_REMOVE, 32'h8000_0000);
    send_request(OP_INSERT, 32'h5555_5555);
    send_request(OP_INSERT, 32'hAAAA_AAAA);
    send_request(OP_LOOKUP, 32'h5555_5555);
    send_request(OP_REMOVE, 32'h0000_0000);
    send_request(OP_CLEAR,  32'h0000_0000);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF);
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 87; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 87; end
        default: begin send_idle = 21; stall_pct = 21; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_request(pick_op(((n / 96) % 2) == 0), pick_key());
      wait_drained();
    end

    // Back pressure: receiver holds off while requests keep coming
    send_idle = 0;
    stall_pct = 0;
    hold_len  = HOLD_CYCLES;
    for (int n = 0; n < 24; n++) send_request(pick_op(n < 16), pick_key());
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
